// ===== src/trp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package trp_pkg;

  localparam int PIX_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 4;
  localparam int PKT_W     = 10;
  localparam int DOT_CNT_W = 3;

  localparam int ROWS_PER_PACKET_DEF = 10;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [COL_W-1:0]  ROW_BYTES_RST      = 7'd72;
  localparam logic [PKT_W-1:0]  PACKET_TOTAL_RST   = 10'd150;
  localparam logic [PIX_W-1:0]  DARK_THRESHOLD_RST = 8'd128;

  localparam logic [DOT_CNT_W-1:0] DOT_LAST = 3'd7;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_ROW_BYTES      = 2'd0,
    REG_PACKET_TOTAL   = 2'd1,
    REG_DARK_THRESHOLD = 2'd2,
    REG_NONE           = 2'd3
  } reg_idx_t;

  localparam logic [BYTE_W-1:0] HDR_SYNC   = 8'h68;
  localparam logic [BYTE_W-1:0] HDR_CMD    = 8'h02;
  localparam logic [BYTE_W-1:0] HDR_TAIL   = 8'hDA;
  localparam logic [BYTE_W-1:0] ROW_START  = 8'hA5;
  localparam logic [BYTE_W-1:0] TRAIL_PAD  = 8'h00;
  localparam logic [BYTE_W-1:0] TRAIL_END  = 8'h16;

  // one completed data byte plus the framing it carries
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              hdr;
    logic              row_start;
    logic              trailer;
    logic              last;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_HDR0 = 3'd0,
    ST_HDR1 = 3'd1,
    ST_HDR2 = 3'd2,
    ST_HDR3 = 3'd3,
    ST_ROW  = 3'd4,
    ST_DATA = 3'd5,
    ST_PAD  = 3'd6,
    ST_END  = 3'd7
  } step_t;

  function automatic logic [BYTE_W-1:0] step_byte(input step_t st, input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] b;
    begin
      unique case (st)
        ST_HDR0: b = HDR_SYNC;
        ST_HDR1: b = HDR_CMD;
        ST_HDR2: b = HDR_CMD;
        ST_HDR3: b = HDR_TAIL;
        ST_ROW:  b = ROW_START;
        ST_DATA: b = d;
        ST_PAD:  b = TRAIL_PAD;
        ST_END:  b = TRAIL_END;
        default: b = d;
      endcase
      return b;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/trp_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface trp_pix_if
  import trp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_red;

  modport source (output valid, output pixel_red, input ready);
  modport sink   (input valid, input pixel_red, output ready);
endinterface
`default_nettype wire

// ===== src/trp_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface trp_byte_if
  import trp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              packet_done;
  logic              image_done;

  modport source (output valid, output out_byte, output run_last, output packet_done,
                  output image_done, input ready);
  modport sink   (input valid, input out_byte, input run_last, input packet_done,
                  input image_done, output ready);
endinterface
`default_nettype wire

// ===== src/trp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trp_front
  import trp_pkg::*;
#(
  parameter int ROWS_PER_PACKET = ROWS_PER_PACKET_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  trp_pix_if.sink          in_pix,
  input  logic [COL_W-1:0] row_bytes,
  input  logic [PKT_W-1:0] packet_total,
  input  logic [PIX_W-1:0] dark_threshold,
  input  q_stat_t          q_stat,
  output logic             push,
  output job_t             job
);

  logic [PIX_W-1:0]     shift_r, shift_nxt;
  logic [DOT_CNT_W-1:0] dot_cnt_r, dot_cnt_nxt;
  logic [COL_W-1:0]     col_r, col_nxt, col_inc;
  logic [ROW_W-1:0]     row_r, row_nxt, row_inc;
  logic [PKT_W-1:0]     pkt_r, pkt_nxt, pkt_inc;
  logic                 accept;
  logic                 dot;
  logic [PIX_W-1:0]     shifted;

  // only the eighth dot needs a queue slot
  assign in_pix.ready = (dot_cnt_r != DOT_LAST) || !q_stat.full;
  assign accept       = in_pix.valid && in_pix.ready;

  assign dot     = in_pix.pixel_red < dark_threshold;
  assign shifted = {shift_r[PIX_W-2:0], dot};
  assign col_inc = col_r + 1'b1;
  assign row_inc = row_r + 1'b1;
  assign pkt_inc = pkt_r + 1'b1;

  always_comb begin
    shift_nxt     = shift_r;
    dot_cnt_nxt   = dot_cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pkt_nxt       = pkt_r;
    push          = 1'b0;
    job.data      = shifted;
    job.hdr       = (col_r == '0) && (row_r == '0);
    job.row_start = (col_r == '0);
    job.trailer   = 1'b0;
    job.last      = 1'b0;
    if (accept) begin
      if (dot_cnt_r != DOT_LAST) begin
        shift_nxt   = shifted;
        dot_cnt_nxt = dot_cnt_r + 1'b1;
      end else begin
        push        = 1'b1;
        shift_nxt   = '0;
        dot_cnt_nxt = '0;
        if (col_inc == row_bytes) begin
          col_nxt = '0;
          if (row_inc == ROW_W'(ROWS_PER_PACKET)) begin
            row_nxt     = '0;
            job.trailer = 1'b1;
            job.last    = (pkt_inc == packet_total);
            pkt_nxt     = job.last ? '0 : pkt_inc;
          end else begin
            row_nxt = row_inc;
          end
        end else begin
          col_nxt = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= '0;
      dot_cnt_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      pkt_r     <= '0;
    end else begin
      shift_r   <= shift_nxt;
      dot_cnt_r <= dot_cnt_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pkt_r     <= pkt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/trp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trp_queue
  import trp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head             = mem_r[rd_ptr_r];
  assign q_stat.full      = (count_r == CNT_W'(DEPTH));
  assign q_stat.not_empty = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/trp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trp_back
  import trp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  q_stat_t     q_stat,
  output logic        pop,
  trp_byte_if.source  out_pkt
);

  step_t             step_r, step_nxt, cur;
  logic              started_r, started_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              run_last_r, pkt_done_r, img_done_r;
  logic              load_ok, fire, is_final;
  step_t             first_step, after;

  assign out_pkt.valid       = valid_r;
  assign out_pkt.out_byte    = byte_r;
  assign out_pkt.run_last    = run_last_r;
  assign out_pkt.packet_done = pkt_done_r;
  assign out_pkt.image_done  = img_done_r;

  always_comb begin
    first_step = head.hdr ? ST_HDR0 : (head.row_start ? ST_ROW : ST_DATA);
    cur        = started_r ? step_r : first_step;
    load_ok    = !valid_r || out_pkt.ready;
    fire       = q_stat.not_empty && load_ok;
    is_final   = ((cur == ST_DATA) && !head.trailer) || (cur == ST_END);
    pop        = fire && is_final;
    unique case (cur)
      ST_HDR0: after = ST_HDR1;
      ST_HDR1: after = ST_HDR2;
      ST_HDR2: after = ST_HDR3;
      ST_HDR3: after = ST_ROW;
      ST_ROW:  after = ST_DATA;
      ST_DATA: after = ST_PAD;
      ST_PAD:  after = ST_END;
      ST_END:  after = ST_HDR0;
      default: after = ST_HDR0;
    endcase
    step_nxt    = fire ? after : step_r;
    started_nxt = fire ? !is_final : started_r;
    valid_nxt   = fire ? 1'b1 : (out_pkt.ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_HDR0;
      started_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      started_r <= started_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r     <= step_byte(cur, head.data);
      run_last_r <= is_final;
      pkt_done_r <= (cur == ST_END);
      img_done_r <= (cur == ST_END) && head.last;
    end
  end

endmodule
`default_nettype wire

// ===== src/thermal_raster_packetizer.sv =====
// Thermal raster packetizer.
// in_pix carries one 8-bit red value per transaction, in print order. Each
// value below dark_threshold becomes a dark dot; eight dots pack MSB-first
// into a data byte. out_pkt carries the printer byte stream: every packet
// opens with 68 02 02 DA, every row with A5, every packet closes with 00 16.
// run_last marks the final byte caused by a pixel, packet_done and
// image_done mark the closing 16 of a packet and of the last packet.
// The APB port (byte addresses 0, 4, 8) holds row_bytes, packet_total and
// dark_threshold; write it only while the stream is idle.
// Throughput: one pixel per cycle. A byte-completing pixel yields 1 to 8
// output bytes, sent one per cycle by the output sequencer while out_pkt
// is ready; the job queue between the packer and the sequencer absorbs
// framing bursts, so the input stalls only when the queue fills and an
// eighth dot arrives. Each group passes through the job queue and then the
// output register. When out_pkt stalls, the output register holds and the
// queue fills. Reset clears all counters, the queue and the output valid,
// and loads the register defaults 72, 150 and 128.
`timescale 1ns / 1ps
`default_nettype none
module thermal_raster_packetizer
  import trp_pkg::*;
#(
  parameter int ROWS_PER_PACKET = ROWS_PER_PACKET_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  trp_pix_if.sink               in_pix,
  trp_byte_if.source            out_pkt,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [COL_W-1:0] row_bytes_r;
  logic [PKT_W-1:0] packet_total_r;
  logic [PIX_W-1:0] dark_threshold_r;
  logic             wr_en;
  reg_idx_t         reg_idx;
  logic             push, pop;
  job_t             push_job, head;
  q_stat_t          q_stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r      <= ROW_BYTES_RST;
      packet_total_r   <= PACKET_TOTAL_RST;
      dark_threshold_r <= DARK_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROW_BYTES:      row_bytes_r      <= pwdata[COL_W-1:0];
        REG_PACKET_TOTAL:   packet_total_r   <= pwdata[PKT_W-1:0];
        REG_DARK_THRESHOLD: dark_threshold_r <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_BYTES:      prdata = CFG_DATA_W'(row_bytes_r);
      REG_PACKET_TOTAL:   prdata = CFG_DATA_W'(packet_total_r);
      REG_DARK_THRESHOLD: prdata = CFG_DATA_W'(dark_threshold_r);
      default:            prdata = '0;
    endcase
  end

  trp_front #(
    .ROWS_PER_PACKET(ROWS_PER_PACKET)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pix        (in_pix),
    .row_bytes     (row_bytes_r),
    .packet_total  (packet_total_r),
    .dark_threshold(dark_threshold_r),
    .q_stat        (q_stat),
    .push          (push),
    .job           (push_job)
  );

  trp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  trp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_pkt(out_pkt)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("job pushed into a full queue");

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("job popped from an empty queue");

  a_trailer_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pkt.valid && out_pkt.packet_done) |->
      (out_pkt.out_byte == TRAIL_END) && out_pkt.run_last)
    else $error("packet end flag on a byte other than the closing trailer");

  a_image_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pkt.valid && out_pkt.image_done) |-> out_pkt.packet_done)
    else $error("image end without packet end");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import trp_pkg::*;

  localparam int ROWS         = ROWS_PER_PACKET_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              packet_done;
    logic              image_done;
  } pkt_byte_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  trp_pix_if  in_pix ();
  trp_byte_if out_pkt ();

  thermal_raster_packetizer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pkt (out_pkt),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // packer copy: registers and counters, starting from their reset values
  logic [COL_W-1:0]     row_bytes_q = ROW_BYTES_RST;
  logic [PKT_W-1:0]     pkt_total_q = PACKET_TOTAL_RST;
  logic [PIX_W-1:0]     thresh_q    = DARK_THRESHOLD_RST;
  logic [BYTE_W-1:0]    shift_q     = '0;
  logic [DOT_CNT_W-1:0] dot_cnt_q   = '0;
  logic [COL_W-1:0]     col_q       = '0;
  logic [ROW_W-1:0]     row_q       = '0;
  logic [PKT_W-1:0]     pkt_q       = '0;

  pkt_byte_t bytes_due[$];
  int        errors = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) out_pkt.ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void push_byte(logic [BYTE_W-1:0] b, logic pd, logic id);
    pkt_byte_t e;
    e = '{out_byte: b, run_last: 1'b0, packet_done: pd, image_done: id};
    bytes_due.push_back(e);
  endfunction

  // shift in one dot; on the eighth, queue the data byte with its framing
  function automatic void pack_pixel(input logic [PIX_W-1:0] red);
    logic [BYTE_W-1:0] data;
    logic              last_pkt;
    pkt_byte_t         tail;
    shift_q = {shift_q[BYTE_W-2:0], red < thresh_q};
    if (dot_cnt_q != DOT_LAST) begin
      dot_cnt_q = dot_cnt_q + 1'b1;
      return;
    end
    data      = shift_q;
    dot_cnt_q = '0;
    shift_q   = '0;
    if (col_q == '0 && row_q == '0) begin
      push_byte(HDR_SYNC, 1'b0, 1'b0);
      push_byte(HDR_CMD, 1'b0, 1'b0);
      push_byte(HDR_CMD, 1'b0, 1'b0);
      push_byte(HDR_TAIL, 1'b0, 1'b0);
    end
    if (col_q == '0) push_byte(ROW_START, 1'b0, 1'b0);
    push_byte(data, 1'b0, 1'b0);
    col_q = col_q + 1'b1;
    if (col_q == row_bytes_q) begin
      col_q = '0;
      row_q = row_q + 1'b1;
      if (row_q == ROW_W'(ROWS)) begin
        row_q    = '0;
        pkt_q    = pkt_q + 1'b1;
        last_pkt = (pkt_q == pkt_total_q);
        if (last_pkt) pkt_q = '0;
        push_byte(TRAIL_PAD, 1'b0, 1'b0);
        push_byte(TRAIL_END, 1'b1, last_pkt);
      end
    end
    tail = bytes_due.pop_back();
    tail.run_last = 1'b1;
    bytes_due.push_back(tail);
  endfunction

  always @(posedge clk) begin
    pkt_byte_t want;
    if (rst_n && out_pkt.valid && out_pkt.ready) begin
      if (bytes_due.size() == 0) begin
        $error("out_byte: no byte pending, got 'h%0h", out_pkt.out_byte);
        errors++;
      end else begin
        want = bytes_due.pop_front();
        check_field("out_byte", want.out_byte, out_pkt.out_byte);
        check_field("run_last", want.run_last, out_pkt.run_last);
        check_field("packet_done", want.packet_done, out_pkt.packet_done);
        check_field("image_done", want.image_done, out_pkt.image_done);
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] red);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(negedge clk);
    end
    in_pix.valid     <= 1'b1;
    in_pix.pixel_red <= red;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    pack_pixel(red);
  endtask

  // drop valid, then hold until every pending byte is out and the packer is quiet
  task automatic wait_drained();
    @(negedge clk);
    in_pix.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_read(input reg_idx_t idx, output logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    val = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check(input reg_idx_t idx, input string name, input int want);
    logic [CFG_DATA_W-1:0] got;
    reg_read(idx, got);
    check_field(name, want, got);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ROW_BYTES:      row_bytes_q = val[COL_W-1:0];
      REG_PACKET_TOTAL:   pkt_total_q = val[PKT_W-1:0];
      REG_DARK_THRESHOLD: thresh_q    = val[PIX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input int rb, input int pt, input int thr);
    wait_drained();
    reg_write(REG_ROW_BYTES, rb);
    reg_write(REG_PACKET_TOTAL, pt);
    reg_write(REG_DARK_THRESHOLD, thr);
    reg_check(REG_ROW_BYTES, "row_bytes", row_bytes_q);
    reg_check(REG_PACKET_TOTAL, "packet_total", pkt_total_q);
    reg_check(REG_DARK_THRESHOLD, "dark_threshold", thresh_q);
  endtask

  task automatic test_register_defaults();
    reg_check(REG_ROW_BYTES, "row_bytes", row_bytes_q);
    reg_check(REG_PACKET_TOTAL, "packet_total", pkt_total_q);
    reg_check(REG_DARK_THRESHOLD, "dark_threshold", thresh_q);
  endtask

  // threshold edges: default, zero (all blank), full scale
  task automatic test_pixel_extremes();
    logic [PIX_W-1:0] pat [8];
    send_idle_pct  = 21;
    recv_stall_pct = 83;
    pat = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254, 8'd128, 8'd127};
    foreach (pat[i]) send_pixel(pat[i]);
    configure(1, 1, 0);
    pat = '{8'd0, 8'd1, 8'd255, 8'd0, 8'd128, 8'd0, 8'd254, 8'd0};
    foreach (pat[i]) send_pixel(pat[i]);
    configure(1, 1, 255);
    pat = '{8'd254, 8'd255, 8'd0, 8'd255, 8'd253, 8'd255, 8'd254, 8'd254};
    foreach (pat[i]) send_pixel(pat[i]);
  endtask

  // zero row length: the row keeps running with no row start after its first byte
  task automatic test_row_wrap();
    configure(0, 2, $urandom_range(255));
    repeat (9 * 8) send_pixel($urandom_range(255));
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input bit pause);
    int rb;
    int pt;
    int thr;
    int red;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(3))
        0: rb = 1;
        1: rb = 2;
        2: rb = 72;
        default: rb = $urandom_range(1, 72);
      endcase
      case ($urandom_range(3))
        0: pt = 1;
        1: pt = 2;
        2: pt = 1023;
        default: pt = $urandom_range(1, 1023);
      endcase
      case ($urandom_range(4))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(255);
      endcase
      configure(rb, pt, thr);
      for (int i = 0; i < 11; i++) begin
        if (pause && ph == 0 && i == 5) wait_drained();
        if ($urandom_range(3) == 0) begin
          red = thr + $urandom_range(2) - 1;
          if (red < 0) red = 0;
          if (red > 255) red = 255;
        end else begin
          red = $urandom_range(255);
        end
        send_pixel(red);
      end
    end
  endtask

  // zero packet count: the packet counter runs past zero, so no image end shows
  task automatic test_image_wrap();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(1, 0, $urandom_range(1, 255));
    repeat (2 * ROWS * 8) send_pixel($urandom_range(255));
  endtask

  initial begin
    rst_n            = 1'b0;
    in_pix.valid     = 1'b0;
    in_pix.pixel_red = '0;
    out_pkt.ready    = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_pixel_extremes();
    test_row_wrap();
    test_random_traffic(21, 83, 1'b1);
    test_random_traffic(83, 21, 1'b0);
    test_random_traffic(0, 0, 1'b0);
    test_image_wrap();
    wait_drained();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
